/* rtl/assert_macros.svh */
// assertion macros used by matrix2x2_alu_core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rstn, prop)
`define ASSERT_IMP(label, clk, rstn, ante, cons)
`endif
`endif

/* rtl/m2a_pkg.sv */
// shared types and constants of the 2x2 matrix unit
`default_nettype none
package m2a_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        CMD_ADD   = 3'd0,
        CMD_SUB   = 3'd1,
        CMD_MUL   = 3'd2,
        CMD_SCALE = 3'd3,
        CMD_TRANS = 3'd4,
        CMD_DET   = 3'd5,
        CMD_INV   = 3'd6,
        CMD_IDENT = 3'd7
    } cmd_t;

    // one lane computes round(x1*y1 + x2*y2)
    typedef struct packed {
        logic signed [DATA_W:0]   x1;
        logic signed [DATA_W-1:0] y1;
        logic signed [DATA_W:0]   x2;
        logic signed [DATA_W-1:0] y2;
    } lane_op_t;

endpackage
`default_nettype wire

/* rtl/m2a_lane.sv */
// product lane: two products, exact sum, round to nearest and saturate
`default_nettype none
module m2a_lane
    import m2a_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     en,
    input  wire lane_op_t                 op,
    output logic signed [DATA_W-1:0]      res,
    output logic                          ovf
);
    localparam int PW = 2 * DATA_W + 2;
    localparam int SW = PW + 1;
    localparam logic signed [SW-1:0] MAXV = {{(SW-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    localparam logic signed [SW-1:0] MINV = ~MAXV;
    localparam logic signed [SW-1:0] HALF = SW'(1) <<< (FRAC_BITS - 1);

    lane_op_t               op_reg;
    logic signed [PW-1:0]   p1_reg, p2_reg, p1_next, p2_next;
    logic signed [SW-1:0]   sum_w, rnd_w;
    logic signed [DATA_W-1:0] res_reg, res_next;
    logic                   ovf_reg, ovf_next;

    always_comb begin
        p1_next = PW'(op_reg.x1) * PW'(op_reg.y1);
        p2_next = PW'(op_reg.x2) * PW'(op_reg.y2);
        sum_w   = SW'(p1_reg) + SW'(p2_reg);
        rnd_w   = (sum_w + HALF) >>> FRAC_BITS;
        if (rnd_w > MAXV) begin
            res_next = MAXV[DATA_W-1:0];
            ovf_next = 1'b1;
        end else if (rnd_w < MINV) begin
            res_next = MINV[DATA_W-1:0];
            ovf_next = 1'b1;
        end else begin
            res_next = rnd_w[DATA_W-1:0];
            ovf_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            op_reg  <= op;
            p1_reg  <= p1_next;
            p2_reg  <= p2_next;
            res_reg <= res_next;
            ovf_reg <= ovf_next;
        end
    end

    assign res = res_reg;
    assign ovf = ovf_reg;
endmodule
`default_nettype wire

/* rtl/m2a_div.sv */
// pipelined restoring divider, one quotient bit per stage, truncating, saturated
`default_nettype none
module m2a_div
    import m2a_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     en,
    input  wire logic signed [DATA_W:0]   num,
    input  wire logic signed [DATA_W-1:0] den,
    output logic signed [DATA_W-1:0]      quo,
    output logic                          ovf
);
    localparam int QW = DATA_W + FRAC_BITS;
    localparam logic [QW-1:0] LIM = {{(QW-DATA_W){1'b0}}, 1'b1, {(DATA_W-1){1'b0}}};

    logic [DATA_W-1:0] rem_reg [QW];
    logic [QW-1:0]     n_reg   [QW];
    logic [DATA_W-1:0] d_reg   [QW];
    logic              neg_reg [QW];

    logic [DATA_W:0]   n_abs, d_abs;
    logic [QW-1:0]     q_w;

    assign n_abs = num[DATA_W] ? -num : num;
    assign d_abs = den[DATA_W-1] ? -{den[DATA_W-1], den} : {1'b0, den};

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DATA_W-1:0] rem_in, rem_out;
        logic [QW-1:0]     n_in, n_out;
        logic [DATA_W-1:0] d_in;
        logic              neg_in;
        logic [DATA_W:0]   trial, diff;
        logic              ge;

        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign n_in   = {n_abs[DATA_W-1:0], {FRAC_BITS{1'b0}}};
            assign d_in   = d_abs[DATA_W-1:0];
            assign neg_in = num[DATA_W] ^ den[DATA_W-1];
        end else begin : g_next
            assign rem_in = rem_reg[k-1];
            assign n_in   = n_reg[k-1];
            assign d_in   = d_reg[k-1];
            assign neg_in = neg_reg[k-1];
        end

        always_comb begin
            trial   = {rem_in, n_in[QW-1]};
            diff    = trial - {1'b0, d_in};
            ge      = trial >= {1'b0, d_in};
            rem_out = ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
            n_out   = {n_in[QW-2:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= rem_out;
                n_reg[k]   <= n_out;
                d_reg[k]   <= d_in;
                neg_reg[k] <= neg_in;
            end
        end
    end

    assign q_w = n_reg[QW-1];

    always_comb begin
        if (neg_reg[QW-1]) begin
            if (q_w > LIM) begin
                quo = LIM[DATA_W-1:0];
                ovf = 1'b1;
            end else begin
                quo = -q_w[DATA_W-1:0];
                ovf = 1'b0;
            end
        end else begin
            if (q_w >= LIM) begin
                quo = ~LIM[DATA_W-1:0];
                ovf = 1'b1;
            end else begin
                quo = q_w[DATA_W-1:0];
                ovf = 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

/* rtl/matrix2x2_alu_core.sv */
// top level of the 2x2 matrix unit: four product lanes, four dividers, merge stage
//
// Input channel s_*: command, matrix A, matrix B and scalar, all signed fixed point
// with FRAC_BITS fraction bits. Result channel m_*: four entries plus singular and
// overflow flags. Each transfer in gives exactly one transfer out, in order.
// From input transfer to m_valid, the transfer edge loads the first of three lane
// stages (operand, product, round), then one stage per quotient bit of the divider
// (32 + FRAC_BITS), then the output register.
// Every command travels the full pipeline, so results never reorder.
// Throughput is one item per cycle while the receiver does not stall. When the
// receiver holds m_ready low while m_valid is high, the whole pipeline freezes and
// s_ready drops in the same cycle; nothing is lost. Reset clears all valid bits;
// payload registers are not reset.
`default_nettype none
`include "assert_macros.svh"
module matrix2x2_alu_core
    import m2a_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [2:0]               s_command,
    input  wire logic signed [DATA_W-1:0] s_a_11,
    input  wire logic signed [DATA_W-1:0] s_a_12,
    input  wire logic signed [DATA_W-1:0] s_a_21,
    input  wire logic signed [DATA_W-1:0] s_a_22,
    input  wire logic signed [DATA_W-1:0] s_b_11,
    input  wire logic signed [DATA_W-1:0] s_b_12,
    input  wire logic signed [DATA_W-1:0] s_b_21,
    input  wire logic signed [DATA_W-1:0] s_b_22,
    input  wire logic signed [DATA_W-1:0] s_scalar,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic signed [DATA_W-1:0]      m_r_11,
    output logic signed [DATA_W-1:0]      m_r_12,
    output logic signed [DATA_W-1:0]      m_r_21,
    output logic signed [DATA_W-1:0]      m_r_22,
    output logic                          m_singular,
    output logic                          m_overflow
);
    localparam int QW = DATA_W + FRAC_BITS;
    localparam int LANE_LAT = 3;
    localparam int DEPTH = LANE_LAT + QW;

    typedef struct packed {
        cmd_t                   cmd;
        logic [3:0][DATA_W-1:0] a;
        logic [3:0][DATA_W-1:0] dr;
        logic                   dovf;
    } sb1_t;

    typedef struct packed {
        cmd_t                   cmd;
        logic [3:0][DATA_W-1:0] pre;
        logic                   pre_ovf;
        logic                   det_zero;
        logic                   det_ovf;
    } sb2_t;

    function automatic logic [DATA_W:0] sat33(input logic signed [DATA_W:0] x);
        logic [DATA_W:0] r;
        if (x > $signed({2'b00, {(DATA_W-1){1'b1}}})) begin
            r = {1'b1, 1'b0, {(DATA_W-1){1'b1}}};
        end else if (x < $signed({2'b11, {(DATA_W-1){1'b0}}})) begin
            r = {1'b1, 1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            r = {1'b0, x[DATA_W-1:0]};
        end
        return r;
    endfunction

    logic en;
    logic signed [DATA_W-1:0] a_in [4];
    logic signed [DATA_W-1:0] b_in [4];
    cmd_t     cmd_in;
    lane_op_t lane_op [4];
    logic signed [DATA_W-1:0] lane_res [4];
    logic     lane_ovf [4];
    logic signed [DATA_W:0]   adj [4];
    logic signed [DATA_W-1:0] div_q [4];
    logic     div_ovf [4];
    logic [DATA_W:0] sat_w [4];

    sb1_t sb1_next;
    sb1_t sb1_reg [LANE_LAT];
    sb2_t sb2_next;
    sb2_t sb2_reg [QW];
    sb1_t sb1_cur;
    sb2_t sb2_cur;

    logic [DEPTH-1:0] vld_reg;
    logic             m_valid_reg;
    logic [3:0][DATA_W-1:0] r_reg, r_next;
    logic             sing_reg, sing_next, ovf_reg, ovf_next;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;
    assign cmd_in  = cmd_t'(s_command);

    assign a_in[0] = s_a_11;
    assign a_in[1] = s_a_12;
    assign a_in[2] = s_a_21;
    assign a_in[3] = s_a_22;
    assign b_in[0] = s_b_11;
    assign b_in[1] = s_b_12;
    assign b_in[2] = s_b_21;
    assign b_in[3] = s_b_22;

    // operand selection for the lanes
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            lane_op[i] = '0;
        end
        case (cmd_in)
            CMD_MUL: begin
                lane_op[0] = '{x1: 33'(a_in[0]), y1: b_in[0], x2: 33'(a_in[1]), y2: b_in[2]};
                lane_op[1] = '{x1: 33'(a_in[0]), y1: b_in[1], x2: 33'(a_in[1]), y2: b_in[3]};
                lane_op[2] = '{x1: 33'(a_in[2]), y1: b_in[0], x2: 33'(a_in[3]), y2: b_in[2]};
                lane_op[3] = '{x1: 33'(a_in[2]), y1: b_in[1], x2: 33'(a_in[3]), y2: b_in[3]};
            end
            CMD_SCALE: begin
                for (int i = 0; i < 4; i++) begin
                    lane_op[i] = '{x1: 33'(a_in[i]), y1: s_scalar, x2: '0, y2: '0};
                end
            end
            CMD_DET, CMD_INV: begin
                lane_op[0] = '{x1: 33'(a_in[0]), y1: a_in[3], x2: -33'(a_in[1]), y2: a_in[2]};
            end
            default: begin
            end
        endcase
    end

    // results that need no product
    always_comb begin
        sb1_next.cmd  = cmd_in;
        sb1_next.dovf = 1'b0;
        for (int i = 0; i < 4; i++) begin
            sb1_next.a[i]  = a_in[i];
            sb1_next.dr[i] = '0;
            sat_w[i]       = '0;
        end
        case (cmd_in)
            CMD_ADD, CMD_SUB: begin
                for (int i = 0; i < 4; i++) begin
                    sat_w[i] = (cmd_in == CMD_ADD) ? sat33(33'(a_in[i]) + 33'(b_in[i]))
                                                   : sat33(33'(a_in[i]) - 33'(b_in[i]));
                    sb1_next.dr[i] = sat_w[i][DATA_W-1:0];
                    sb1_next.dovf  = sb1_next.dovf | sat_w[i][DATA_W];
                end
            end
            CMD_TRANS: begin
                sb1_next.dr[0] = a_in[0];
                sb1_next.dr[1] = a_in[2];
                sb1_next.dr[2] = a_in[1];
                sb1_next.dr[3] = a_in[3];
            end
            CMD_IDENT: begin
                sb1_next.dr[0] = DATA_W'(1) << FRAC_BITS;
                sb1_next.dr[3] = DATA_W'(1) << FRAC_BITS;
            end
            default: begin
            end
        endcase
    end

    for (genvar i = 0; i < 4; i++) begin : g_lane
        m2a_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
            .aclk (aclk),
            .en   (en),
            .op   (lane_op[i]),
            .res  (lane_res[i]),
            .ovf  (lane_ovf[i])
        );

        m2a_div #(.FRAC_BITS(FRAC_BITS)) u_div (
            .aclk (aclk),
            .en   (en),
            .num  (adj[i]),
            .den  (lane_res[0]),
            .quo  (div_q[i]),
            .ovf  (div_ovf[i])
        );
    end

    assign sb1_cur = sb1_reg[LANE_LAT-1];
    assign sb2_cur = sb2_reg[QW-1];

    assign adj[0] = 33'($signed(sb1_cur.a[3]));
    assign adj[1] = -33'($signed(sb1_cur.a[1]));
    assign adj[2] = -33'($signed(sb1_cur.a[2]));
    assign adj[3] = 33'($signed(sb1_cur.a[0]));

    // lane results merged with the bypass results
    always_comb begin
        sb2_next.cmd      = sb1_cur.cmd;
        sb2_next.pre      = '0;
        sb2_next.pre_ovf  = 1'b0;
        sb2_next.det_zero = (lane_res[0] == '0);
        sb2_next.det_ovf  = lane_ovf[0];
        case (sb1_cur.cmd)
            CMD_MUL, CMD_SCALE: begin
                for (int i = 0; i < 4; i++) begin
                    sb2_next.pre[i] = lane_res[i];
                end
                sb2_next.pre_ovf = lane_ovf[0] | lane_ovf[1] | lane_ovf[2] | lane_ovf[3];
            end
            CMD_DET: begin
                sb2_next.pre[0]  = lane_res[0];
                sb2_next.pre_ovf = lane_ovf[0];
            end
            CMD_INV: begin
            end
            default: begin
                sb2_next.pre     = sb1_cur.dr;
                sb2_next.pre_ovf = sb1_cur.dovf;
            end
        endcase
    end

    // output merge
    always_comb begin
        r_next    = sb2_cur.pre;
        sing_next = 1'b0;
        ovf_next  = sb2_cur.pre_ovf;
        if (sb2_cur.cmd == CMD_INV) begin
            if (sb2_cur.det_zero) begin
                r_next    = '0;
                sing_next = 1'b1;
                ovf_next  = 1'b0;
            end else begin
                for (int i = 0; i < 4; i++) begin
                    r_next[i] = div_q[i];
                end
                ovf_next = sb2_cur.det_ovf | div_ovf[0] | div_ovf[1] | div_ovf[2] | div_ovf[3];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sb1_reg[0] <= sb1_next;
            for (int k = 1; k < LANE_LAT; k++) begin
                sb1_reg[k] <= sb1_reg[k-1];
            end
            sb2_reg[0] <= sb2_next;
            for (int k = 1; k < QW; k++) begin
                sb2_reg[k] <= sb2_reg[k-1];
            end
            r_reg    <= r_next;
            sing_reg <= sing_next;
            ovf_reg  <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= {vld_reg[DEPTH-2:0], s_valid};
            m_valid_reg <= vld_reg[DEPTH-1];
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_r_11     = r_reg[0];
    assign m_r_12     = r_reg[1];
    assign m_r_21     = r_reg[2];
    assign m_r_22     = r_reg[3];
    assign m_singular = sing_reg;
    assign m_overflow = ovf_reg;

    `ASSERT_CLK(a_ready_follows_stall, aclk, aresetn, s_ready == (!m_valid || m_ready))
    `ASSERT_IMP(a_sing_no_ovf, aclk, aresetn, m_valid && m_singular, !m_overflow)
    `ASSERT_IMP(a_sing_zero, aclk, aresetn, m_valid && m_singular, (m_r_11 == '0) && (m_r_12 == '0) && (m_r_21 == '0) && (m_r_22 == '0))
endmodule
`default_nettype wire
